[rtl/krmss_pkg.sv]
// krmss_pkg: widths, modulus constants and the saturating add helper
// for the k-repeat max subarray sum block. no dependencies.
package krmss_pkg;

  localparam int ELEM_W = 16;   // element width, two's complement
  localparam int K_W    = 17;   // repeat count width
  localparam int OUT_W  = 30;   // result width
  localparam int SUM_W  = 33;   // running state width
  localparam int BASE_W = 34;   // max(best, wrap), never negative
  localparam int PROD_W = 49;   // (k-2) * total
  localparam int X_W    = 50;   // base + product
  localparam int XH_W   = 21;   // x >> 29
  localparam int REM_W  = 31;   // remainder before final correction

  localparam logic [OUT_W-1:0] MOD_P = 30'd1000000007;

  // floor(2^61 / p), used to estimate the quotient from x[49:29]
  localparam logic [63:0] RECIP_FULL = 64'h2000_0000_0000_0000 / 64'd1000000007;
  localparam logic [31:0] RECIP      = RECIP_FULL[31:0];

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // clamp a one-bit-wider sum into the state range
  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
    logic signed [SUM_W-1:0] res;
    if (v[SUM_W] != v[SUM_W-1]) begin
      res = v[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      res = v[SUM_W-1:0];
    end
    return res;
  endfunction

endpackage

[rtl/k_repeat_max_subarray_sum.sv]
// k_repeat_max_subarray_sum: streaming max subarray sum of a k-fold repeated
// array, reduced mod 1000000007. depends on krmss_pkg.
//
//   port group   direction  handshake            payload
//   in_*         input      in_valid/in_ready    in_element (16 s), in_last
//   out_*        output     out_valid/out_ready  out_max_sum_mod (30 u)
//   cfg_*        input      cfg_valid/cfg_ready  cfg_repeat_count (17 u)
//
// one element is taken every cycle while in_ready is high; the prefix and
// kadane state update in the cycle of the beat. a last beat launches a
// six-stage tail (capture, combine, add, quotient estimate, quotient times p,
// subtract and correct). in_ready drops only when all six tail stages hold
// results and out_ready is low. rst_n is synchronous: it clears the state,
// sets the repeat count to 1 and empties the tail; cfg_ready is always high.
module k_repeat_max_subarray_sum (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [krmss_pkg::ELEM_W-1:0] in_element,
  input  logic                            in_last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [krmss_pkg::OUT_W-1:0]     out_max_sum_mod,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [krmss_pkg::K_W-1:0]       cfg_repeat_count
);
  import krmss_pkg::*;

  localparam int NSTG = 6;

  // running state
  logic signed [SUM_W-1:0] total_r, max_r, min_r, cur_r, best_r;
  logic signed [SUM_W-1:0] total_nxt, max_nxt, min_nxt, cur_nxt, best_nxt;
  logic signed [SUM_W-1:0] total_v, max_v, min_v, cur_v, best_v, cur_sat;
  logic [K_W-1:0]          k_r;

  logic signed [SUM_W:0]   e_ext;
  logic                    accept, launch;

  // tail pipeline
  logic [NSTG-1:0]         vld_r, vld_nxt, free;

  logic signed [SUM_W-1:0] s1_total_r, s1_max_r, s1_min_r, s1_best_r;
  logic [K_W-1:0]          s1_k_r;
  logic [BASE_W-1:0]       s2_base_r;
  logic [PROD_W-1:0]       s2_prod_r;
  logic [X_W-1:0]          s3_x_r;
  logic [XH_W-1:0]         s4_q_r;
  logic [REM_W-1:0]        s4_xl_r;
  logic [REM_W-1:0]        s5_qp_r;
  logic [REM_W-1:0]        s5_xl_r;
  logic [OUT_W-1:0]        out_r;

  logic signed [BASE_W:0]  wrap;
  logic signed [BASE_W:0]  best_ext;
  logic [BASE_W-1:0]       base_v;
  logic [K_W-1:0]          factor;
  logic [31:0]             tot_pos;
  logic [XH_W+32-1:0]      q_full;
  logic [XH_W+OUT_W-1:0]   qp_full;
  logic [REM_W-1:0]        rem, rem_sub;

  // per-beat state update
  always_comb begin
    e_ext   = {{(SUM_W+1-ELEM_W){in_element[ELEM_W-1]}}, in_element};
    total_v = sat_sum({total_r[SUM_W-1], total_r} + e_ext);
    max_v   = (total_v > max_r) ? total_v : max_r;
    min_v   = (total_v < min_r) ? total_v : min_r;
    cur_sat = sat_sum({cur_r[SUM_W-1], cur_r} + e_ext);
    cur_v   = cur_sat[SUM_W-1] ? '0 : cur_sat;
    best_v  = (cur_v > best_r) ? cur_v : best_r;

    total_nxt = total_r;
    max_nxt   = max_r;
    min_nxt   = min_r;
    cur_nxt   = cur_r;
    best_nxt  = best_r;
    if (accept) begin
      if (in_last) begin
        total_nxt = '0;
        max_nxt   = '0;
        min_nxt   = '0;
        cur_nxt   = '0;
        best_nxt  = '0;
      end else begin
        total_nxt = total_v;
        max_nxt   = max_v;
        min_nxt   = min_v;
        cur_nxt   = cur_v;
        best_nxt  = best_v;
      end
    end
  end

  // a stage may load when it is empty or its content moves on
  always_comb begin
    free[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int i = NSTG-2; i >= 0; i--) begin
      free[i] = !vld_r[i] || free[i+1];
    end
    vld_nxt[0] = free[0] ? launch : vld_r[0];
    for (int i = 1; i < NSTG; i++) begin
      vld_nxt[i] = free[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  assign in_ready  = free[0];
  assign accept    = in_valid && in_ready;
  assign launch    = accept && in_last;
  assign cfg_ready = 1'b1;

  // stage 2: wrap-around candidate and the multiplier for the middle copies
  always_comb begin
    wrap     = ({{(BASE_W+1-SUM_W){s1_total_r[SUM_W-1]}}, s1_total_r}
              - {{(BASE_W+1-SUM_W){s1_min_r[SUM_W-1]}}, s1_min_r})
              + {{(BASE_W+1-SUM_W){s1_max_r[SUM_W-1]}}, s1_max_r};
    best_ext = {{(BASE_W+1-SUM_W){s1_best_r[SUM_W-1]}}, s1_best_r};
    if (s1_k_r >= K_W'(2) && wrap > best_ext) begin
      base_v = wrap[BASE_W-1:0];
    end else begin
      base_v = best_ext[BASE_W-1:0];
    end
    // total > 0 means it fits 32 unsigned bits
    if (s1_k_r >= K_W'(2) && s1_total_r > 0) begin
      factor = s1_k_r - K_W'(2);
    end else begin
      factor = '0;
    end
    tot_pos = s1_total_r[31:0];
  end

  // stages 4-6: quotient estimate is at most one short, so one correction
  assign q_full  = s3_x_r[X_W-1:X_W-XH_W] * RECIP;
  assign qp_full = s4_q_r * MOD_P;
  assign rem     = s5_xl_r - s5_qp_r;
  assign rem_sub = rem - {1'b0, MOD_P};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      max_r   <= '0;
      min_r   <= '0;
      cur_r   <= '0;
      best_r  <= '0;
      k_r     <= K_W'(1);
      vld_r   <= '0;
    end else begin
      total_r <= total_nxt;
      max_r   <= max_nxt;
      min_r   <= min_nxt;
      cur_r   <= cur_nxt;
      best_r  <= best_nxt;
      vld_r   <= vld_nxt;
      if (cfg_valid && cfg_ready) begin
        k_r <= cfg_repeat_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free[0]) begin
      s1_total_r <= total_v;
      s1_max_r   <= max_v;
      s1_min_r   <= min_v;
      s1_best_r  <= best_v;
      s1_k_r     <= k_r;
    end
    if (free[1]) begin
      s2_base_r <= base_v;
      s2_prod_r <= factor * tot_pos;
    end
    if (free[2]) begin
      s3_x_r <= X_W'(s2_base_r) + X_W'(s2_prod_r);
    end
    if (free[3]) begin
      s4_q_r  <= q_full[XH_W+32-1:32];
      s4_xl_r <= s3_x_r[REM_W-1:0];
    end
    if (free[4]) begin
      s5_qp_r <= qp_full[REM_W-1:0];
      s5_xl_r <= s4_xl_r;
    end
    if (free[5]) begin
      out_r <= (rem >= {1'b0, MOD_P}) ? rem_sub[OUT_W-1:0] : rem[OUT_W-1:0];
    end
  end

  assign out_valid       = vld_r[NSTG-1];
  assign out_max_sum_mod = out_r;

endmodule

[rtl/krmss_checker.sv]
// krmss_checker: port-level assertions for k_repeat_max_subarray_sum,
// bound to the top level below. depends on krmss_pkg.
module krmss_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_last,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [krmss_pkg::OUT_W-1:0] out_max_sum_mod
);
  import krmss_pkg::*;

  // a result beat waiting for the sink keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_max_sum_mod))
    else $error("result beat changed while stalled");

  // results are fully reduced
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_max_sum_mod < MOD_P)
    else $error("result not reduced below modulus");

  // reset empties the result tail
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // input only backs up when the output side is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // a last beat taken while out_valid is low leads to a valid result
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last && !out_valid |-> ##6 out_valid)
    else $error("no result after last beat");

endmodule

bind k_repeat_max_subarray_sum krmss_checker u_krmss_checker (.*);

[tb/krmss_sum_checker.sv]
`timescale 1ns / 1ps
// krmss_sum_checker: watches the element, result and repeat-count channels of
// k_repeat_max_subarray_sum, predicts each array's result and compares it.
// depends on krmss_pkg for the port widths.
module krmss_sum_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [krmss_pkg::ELEM_W-1:0] in_element,
  input  logic                                in_last,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [krmss_pkg::OUT_W-1:0]         out_max_sum_mod,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [krmss_pkg::K_W-1:0]           cfg_repeat_count,
  output int unsigned                         fail_count,
  output int unsigned                         sums_owed
);

  localparam int EW = krmss_pkg::ELEM_W;
  localparam int SW = krmss_pkg::SUM_W;
  localparam int OW = krmss_pkg::OUT_W;
  localparam int KW = krmss_pkg::K_W;

  localparam longint PRIME = 64'sd1000000007;
  localparam longint TOP33 = 64'sd4294967295;
  localparam longint BOT33 = -64'sd4294967296;

  logic signed [SW-1:0] run_total;
  logic signed [SW-1:0] prefix_hi;
  logic signed [SW-1:0] prefix_lo;
  logic signed [SW-1:0] kad_cur;
  logic signed [SW-1:0] kad_best;
  logic [KW-1:0]        copies;
  logic [OW-1:0]        owed_sums[$];
  int unsigned          errors = 0;

  function automatic logic signed [SW-1:0] clamp33(input longint v);
    longint c;
    c = (v > TOP33) ? TOP33 : ((v < BOT33) ? BOT33 : v);
    return c[SW-1:0];
  endfunction

  function automatic void clear_scan();
    run_total = '0;
    prefix_hi = '0;
    prefix_lo = '0;
    kad_cur   = '0;
    kad_best  = '0;
  endfunction

  // fold one element into the prefix and kadane state; a last beat closes the array
  function automatic void scan_element(input logic signed [EW-1:0] e, input logic fin);
    longint cur;
    longint best_sum;
    longint wrap;
    longint rem;
    run_total = clamp33(longint'(run_total) + longint'(e));
    if (run_total > prefix_hi) prefix_hi = run_total;
    if (run_total < prefix_lo) prefix_lo = run_total;
    cur = longint'(clamp33(longint'(kad_cur) + longint'(e)));
    if (cur < 0) cur = 0;
    kad_cur = cur[SW-1:0];
    if (kad_cur > kad_best) kad_best = kad_cur;
    if (fin) begin
      best_sum = longint'(kad_best);
      if (copies >= 2) begin
        // best suffix joined to best prefix across one seam
        wrap = longint'(run_total) - longint'(prefix_lo) + longint'(prefix_hi);
        if (wrap > best_sum) best_sum = wrap;
        if (run_total > 0) best_sum += (longint'(copies) - 2) * longint'(run_total);
      end
      if (best_sum < 0) best_sum = 0;
      rem = best_sum % PRIME;
      owed_sums.push_back(rem[OW-1:0]);
      clear_scan();
    end
  endfunction

  always @(posedge clk) begin : watch
    logic [OW-1:0] want;
    if (!rst_n) begin
      clear_scan();
      copies = KW'(1);
      owed_sums.delete();
    end else begin
      // a result beat can never stem from an element beat on the same edge
      if (out_valid && out_ready) begin
        if (owed_sums.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result %0d with no array pending", $time, out_max_sum_mod);
        end else begin
          want = owed_sums.pop_front();
          if (out_max_sum_mod !== want) begin
            errors++;
            if (errors <= 10)
              $display("%0t: max_sum_mod mismatch: expected %0d, actual %0d",
                       $time, want, out_max_sum_mod);
          end
        end
      end
      if (in_valid && in_ready) scan_element(in_element, in_last);
      if (cfg_valid && cfg_ready) copies = cfg_repeat_count;
    end
    fail_count <= errors;
    sums_owed  <= owed_sums.size();
  end

endmodule

[tb/tb_k_repeat_max_subarray_sum.sv]
`timescale 1ns / 1ps
// tb_k_repeat_max_subarray_sum: drives arrays and repeat counts into the block,
// with random gaps and a long result hold-off, and gives the verdict.
// depends on krmss_pkg, k_repeat_max_subarray_sum and krmss_sum_checker.
module tb_k_repeat_max_subarray_sum;

  localparam int EW = krmss_pkg::ELEM_W;
  localparam int OW = krmss_pkg::OUT_W;
  localparam int KW = krmss_pkg::K_W;
  localparam logic [KW-1:0] K_MAX = '1;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [EW-1:0] in_element;
  logic                 in_last;
  logic                 out_valid;
  logic                 out_ready;
  logic [OW-1:0]        out_max_sum_mod;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [KW-1:0]        cfg_repeat_count;

  int unsigned fail_count;
  int unsigned sums_owed;
  int unsigned items_sent;
  logic        no_gaps;
  logic        press_req;

  k_repeat_max_subarray_sum DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_element      (in_element),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_max_sum_mod (out_max_sum_mod),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_repeat_count(cfg_repeat_count)
  );

  krmss_sum_checker u_sum_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_element      (in_element),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_max_sum_mod (out_max_sum_mod),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_repeat_count(cfg_repeat_count),
    .fail_count      (fail_count),
    .sums_owed       (sums_owed)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // mode 0 mixes extremes, small and full-range values; 1 leans positive, 2 negative
  function automatic logic signed [EW-1:0] pick_element(input int mode);
    logic signed [EW-1:0] v;
    case ($urandom_range(9))
      0:       v = 16'sh7FFF;
      1:       v = 16'sh8000;
      2, 3:    v = EW'($urandom_range(40) - 20);
      default: begin
        if (mode == 1) begin
          v = ($urandom_range(3) == 0) ? EW'(-$urandom_range(300))
                                       : EW'($urandom_range(32767));
        end else if (mode == 2) begin
          v = ($urandom_range(3) == 0) ? EW'($urandom_range(300))
                                       : EW'(-$urandom_range(32768));
        end else begin
          v = EW'($urandom);
        end
      end
    endcase
    return v;
  endfunction

  task automatic push_beat(input logic signed [EW-1:0] e, input logic fin);
    while (!no_gaps && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_element <= e;
    in_last    <= fin;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_array(input int len, input int mode);
    for (int i = 1; i <= len; i++) push_beat(pick_element(mode), i == len);
    items_sent += len;
  endtask

  // wait for every owed result, then let the tail run dry
  task automatic settle(input int tail_cycles);
    @(posedge clk);
    while (sums_owed != 0) @(posedge clk);
    repeat (tail_cycles) @(posedge clk);
  endtask

  task automatic set_repeat(input logic [KW-1:0] k);
    in_valid <= 1'b0;
    settle(8);
    cfg_valid        <= 1'b1;
    cfg_repeat_count <= k;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : result_sink
    bit pressed;
    int hold_cycles;
    pressed = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (press_req && !pressed) begin
        // long hold-off so the tail fills and the input stalls
        pressed = 1'b1;
        out_ready <= 1'b0;
        for (hold_cycles = 0; hold_cycles < 200; hold_cycles++) @(posedge clk);
      end else begin
        out_ready <= no_gaps || ($urandom_range(99) >= 21);
      end
    end
  end

  initial begin : stimulus
    int phase;
    int phase_items;
    int len;
    logic [KW-1:0] k;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_element       <= '0;
    in_last          <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_repeat_count <= '0;
    no_gaps          <= 1'b0;
    press_req        <= 1'b0;
    items_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // k after reset: single element arrays at both extremes, then a short one
    push_beat(16'sh7FFF, 1'b1);
    push_beat(16'sh8000, 1'b1);
    push_beat(16'sd3, 1'b0);
    push_beat(-16'sd5, 1'b0);
    push_beat(16'sd4, 1'b1);
    // repeat count zero acts as a single copy
    set_repeat('0);
    push_beat(16'sd2, 1'b0);
    push_beat(-16'sd1, 1'b0);
    push_beat(16'sd3, 1'b1);
    set_repeat(K_MAX);
    push_beat(16'sh7FFF, 1'b0);
    push_beat(16'sh8000, 1'b0);
    push_beat(16'sh7FFF, 1'b1);
    push_beat(16'sh8000, 1'b0);
    push_beat(16'sd1, 1'b1);
    set_repeat(KW'(2));
    push_beat(-16'sd1, 1'b0);
    push_beat(16'sh7FFF, 1'b0);
    push_beat(-16'sd2, 1'b0);
    push_beat(16'sh7FFF, 1'b1);
    push_beat(16'sd0, 1'b1);

    for (phase = 0; items_sent < 1200; phase++) begin
      case (phase % 8)
        0:       k = '0;
        1:       k = KW'(1);
        2:       k = KW'(2);
        3:       k = K_MAX;
        default: k = ($urandom_range(1) == 0) ? KW'($urandom_range(20, 3)) : KW'($urandom_range(K_MAX));
      endcase
      set_repeat(k);
      no_gaps <= (phase == 3) || (phase == 5);
      phase_items = 0;
      if (phase == 5) begin
        press_req <= 1'b1;
        repeat (40) push_beat(pick_element(0), 1'b1);
        items_sent += 40;
        press_req <= 1'b0;
        no_gaps   <= 1'b0;
      end
      while (phase_items < 150) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(60, 11) : $urandom_range(10, 1);
        send_array(len, $urandom_range(2));
        phase_items += len;
      end
    end

    in_valid <= 1'b0;
    settle(20);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : run_limit
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
